@@ sv/ffilt_pkg.sv @@
// Shared types and constants for the frame address filter.
// No dependencies; used by the control module and the top level.
`timescale 1ns / 1ps

package ffilt_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_OWN_PAN       = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_OWN_ADDR_LOW  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_OWN_ADDR_HIGH = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_EXTRA_ENABLE  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_EXTRA_COUNT   = 3'd4;

  // Input commands.
  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  // Destination addressing modes.
  localparam logic [1:0] MODE_SHORT = 2'd2;
  localparam logic [1:0] MODE_LONG  = 2'd3;

  // Match result codes.
  localparam logic [1:0] MATCH_NONE  = 2'd0;
  localparam logic [1:0] MATCH_OWN   = 2'd1;
  localparam logic [1:0] MATCH_BCAST = 2'd2;

  // Broadcast patterns.
  localparam logic [15:0] BCAST16_A = 16'hFFFF;
  localparam logic [15:0] BCAST16_B = 16'hFFFE;
  localparam logic [31:0] BCAST32_A = 32'hFFFF_FFFF;
  localparam logic [31:0] BCAST32_B = 32'hFFFF_FFFE;

  // Widths fixed by the frame format.
  localparam int unsigned StatusW = 18;
  localparam int unsigned IndexW  = 3;

  typedef struct packed {
    logic [15:0] own_pan;
    logic [31:0] own_addr_low;
    logic [31:0] own_addr_high;
    logic        extra_enable;
    logic [2:0]  extra_count;
  } cfg_t;

endpackage

@@ sv/frame_address_filter.sv @@
// Top level of the frame address filter: configuration registers, table RAM
// and sequencer. Depends on ffilt_pkg, ffilt_ram and ffilt_ctrl.
`timescale 1ns / 1ps

// Destination address filter for received 802.15.4 style frames. Each filter
// transfer carries a frame's status word, destination PAN and addresses; the
// block returns one result transfer with the frame type, CRC and ack flags and
// the destination classification (broadcast, own or extra-table address, or
// no match). A load transfer writes one entry of the extra address table and
// returns nothing. A filter item is captured, classified and put in the
// output register before the next is accepted; a table search comes between
// when the PAN and mode match, neither broadcast nor own address decides it
// and the search is on. The table lives in a RAM with one read port and
// registered read data, so one entry is read and compared per cycle,
// stopping at the first hit. The result waits in an output register, so the
// next item is taken while an earlier result is still stalled. Table entries
// are not cleared by reset; a search must only cover entries that have been
// loaded. Configuration is written through its own port, which is always
// ready, by the user while the block is idle; the block does not enforce it.

module frame_address_filter #(
  parameter int unsigned EXTRA_ENTRIES = 7,
  localparam int unsigned AW = (EXTRA_ENTRIES > 1) ? $clog2(EXTRA_ENTRIES) : 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [17:0] status_word_i,
  input  logic [15:0] dest_pan_i,
  input  logic [31:0] dest_low_i,
  input  logic [31:0] dest_high_i,
  input  logic [31:0] source_low_i,
  input  logic [31:0] source_high_i,
  input  logic [2:0]  entry_index_i,
  input  logic [63:0] entry_value_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        frame_valid_o,
  output logic [1:0]  kind_of_frame_o,
  output logic        crc_ok_o,
  output logic        ack_request_o,
  output logic [1:0]  match_result_o,
  output logic [1:0]  dest_mode_out_o,
  output logic [63:0] dest_address_out_o,
  output logic [63:0] source_address_out_o
);

  ffilt_pkg::cfg_t cfg_q, cfg_d;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_wdata, ram_rdata;

  // The register file accepts a write in every cycle.
  assign cfg_ready_o = 1'b1;

  // Writes to indexes past the last register are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ffilt_pkg::REG_OWN_PAN:       cfg_d.own_pan       = cfg_data_i[15:0];
        ffilt_pkg::REG_OWN_ADDR_LOW:  cfg_d.own_addr_low  = cfg_data_i;
        ffilt_pkg::REG_OWN_ADDR_HIGH: cfg_d.own_addr_high = cfg_data_i;
        ffilt_pkg::REG_EXTRA_ENABLE:  cfg_d.extra_enable  = cfg_data_i[0];
        ffilt_pkg::REG_EXTRA_COUNT:   cfg_d.extra_count   = cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Extra address table, one 64-bit entry per slot.
  ffilt_ram #(
    .WIDTH (64),
    .DEPTH (EXTRA_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ffilt_ctrl #(
    .EXTRA_ENTRIES (EXTRA_ENTRIES)
  ) u_ctrl (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg_q),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .command_i            (command_i),
    .status_word_i        (status_word_i),
    .dest_pan_i           (dest_pan_i),
    .dest_low_i           (dest_low_i),
    .dest_high_i          (dest_high_i),
    .source_low_i         (source_low_i),
    .source_high_i        (source_high_i),
    .entry_index_i        (entry_index_i),
    .entry_value_i        (entry_value_i),
    .ram_we_o             (ram_we),
    .ram_waddr_o          (ram_waddr),
    .ram_wdata_o          (ram_wdata),
    .ram_re_o             (ram_re),
    .ram_raddr_o          (ram_raddr),
    .ram_rdata_i          (ram_rdata),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .frame_valid_o        (frame_valid_o),
    .kind_of_frame_o      (kind_of_frame_o),
    .crc_ok_o             (crc_ok_o),
    .ack_request_o        (ack_request_o),
    .match_result_o       (match_result_o),
    .dest_mode_out_o      (dest_mode_out_o),
    .dest_address_out_o   (dest_address_out_o),
    .source_address_out_o (source_address_out_o)
  );

endmodule

@@ sv/ffilt_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ffilt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 7,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/ffilt_ctrl.sv @@
// Sequencer of the frame address filter: item capture, classification, table
// search through the RAM read port, and the output register. Uses ffilt_pkg.
`timescale 1ns / 1ps

module ffilt_ctrl #(
  parameter int unsigned EXTRA_ENTRIES = 7,
  localparam int unsigned AW = (EXTRA_ENTRIES > 1) ? $clog2(EXTRA_ENTRIES) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ffilt_pkg::cfg_t              cfg_i,
  // Input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         command_i,
  input  logic [ffilt_pkg::StatusW-1:0] status_word_i,
  input  logic [15:0]                  dest_pan_i,
  input  logic [31:0]                  dest_low_i,
  input  logic [31:0]                  dest_high_i,
  input  logic [31:0]                  source_low_i,
  input  logic [31:0]                  source_high_i,
  input  logic [ffilt_pkg::IndexW-1:0] entry_index_i,
  input  logic [63:0]                  entry_value_i,
  // Table RAM
  output logic                         ram_we_o,
  output logic [AW-1:0]                ram_waddr_o,
  output logic [63:0]                  ram_wdata_o,
  output logic                         ram_re_o,
  output logic [AW-1:0]                ram_raddr_o,
  input  logic [63:0]                  ram_rdata_i,
  // Output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         frame_valid_o,
  output logic [1:0]                   kind_of_frame_o,
  output logic                         crc_ok_o,
  output logic                         ack_request_o,
  output logic [1:0]                   match_result_o,
  output logic [1:0]                   dest_mode_out_o,
  output logic [63:0]                  dest_address_out_o,
  output logic [63:0]                  source_address_out_o
);

  localparam int unsigned CW = $clog2(EXTRA_ENTRIES + 1);
  localparam int unsigned LW = (CW > 3) ? CW : 3;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CHECK  = 4'b0010,
    S_SEARCH = 4'b0100,
    S_DONE   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [ffilt_pkg::StatusW-1:0] status_q;
  logic [15:0] pan_q;
  logic [31:0] dlo_q, dhi_q, slo_q, shi_q;
  logic [1:0]  match_q, match_d;
  logic [LW-1:0] idx_q, idx_d;
  logic        pend_q, pend_d;

  logic        accept;
  logic        capture;
  logic        load_in_range;
  logic [LW-1:0] count_w, limit;
  logic [1:0]  mode;
  logic        pan_eq, bcast16, own16, bcast64, own64, search_go, hit;
  logic        out_load;

  logic        out_valid_q;
  logic        frame_valid_q, crc_ok_q, ack_request_q;
  logic [1:0]  kind_q, match_out_q, mode_out_q;
  logic [63:0] daddr_q, saddr_q;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign capture    = accept && (command_i == ffilt_pkg::CMD_FILTER);

  // Table loads complete at the accepting edge; slots past the table are dropped.
  assign load_in_range = (32'(entry_index_i) < EXTRA_ENTRIES);
  assign ram_we_o      = accept && (command_i == ffilt_pkg::CMD_LOAD) && load_in_range;
  assign ram_waddr_o   = AW'(entry_index_i);
  assign ram_wdata_o   = entry_value_i;

  assign count_w   = LW'(cfg_i.extra_count);
  assign limit     = (count_w < LW'(EXTRA_ENTRIES)) ? count_w : LW'(EXTRA_ENTRIES);
  assign search_go = cfg_i.extra_enable && (limit != '0);

  assign mode    = status_q[11:10];
  assign pan_eq  = (pan_q == cfg_i.own_pan);
  assign bcast16 = (dlo_q[15:0] == ffilt_pkg::BCAST16_A) ||
                   (dlo_q[15:0] == ffilt_pkg::BCAST16_B);
  assign own16   = (dlo_q[15:0] == cfg_i.own_addr_low[15:0]);
  assign bcast64 = ((dlo_q == ffilt_pkg::BCAST32_A) || (dlo_q == ffilt_pkg::BCAST32_B)) &&
                   (dhi_q == ffilt_pkg::BCAST32_A);
  assign own64   = (dlo_q == cfg_i.own_addr_low) && (dhi_q == cfg_i.own_addr_high);

  // The entry read in the previous cycle is compared in this one.
  assign hit = pend_q && ((mode == ffilt_pkg::MODE_SHORT) ?
               (ram_rdata_i[15:0] == dlo_q[15:0]) :
               (ram_rdata_i == {dhi_q, dlo_q}));

  assign ram_raddr_o = idx_q[AW-1:0];

  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d  = state_q;
    match_d  = match_q;
    idx_d    = idx_q;
    pend_d   = pend_q;
    ram_re_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (capture) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        match_d = ffilt_pkg::MATCH_NONE;
        idx_d   = '0;
        pend_d  = 1'b0;
        state_d = S_DONE;
        if (pan_eq && (mode == ffilt_pkg::MODE_SHORT)) begin
          if (bcast16) begin
            match_d = ffilt_pkg::MATCH_BCAST;
          end else if (own16) begin
            match_d = ffilt_pkg::MATCH_OWN;
          end else if (search_go) begin
            state_d = S_SEARCH;
          end
        end else if (pan_eq && (mode == ffilt_pkg::MODE_LONG)) begin
          if (bcast64) begin
            match_d = ffilt_pkg::MATCH_BCAST;
          end else if (own64) begin
            match_d = ffilt_pkg::MATCH_OWN;
          end else if (search_go) begin
            state_d = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (hit) begin
          match_d = ffilt_pkg::MATCH_OWN;
          pend_d  = 1'b0;
          state_d = S_DONE;
        end else if (idx_q < limit) begin
          ram_re_o = 1'b1;
          idx_d    = idx_q + LW'(1);
          pend_d   = 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_load ? 1'b1 : (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    match_q <= match_d;
    idx_q   <= idx_d;
    if (capture) begin
      status_q <= status_word_i;
      pan_q    <= dest_pan_i;
      dlo_q    <= dest_low_i;
      dhi_q    <= dest_high_i;
      slo_q    <= source_low_i;
      shi_q    <= source_high_i;
    end
    if (out_load) begin
      frame_valid_q <= !(pan_eq && (mode != ffilt_pkg::MODE_SHORT) &&
                         (mode != ffilt_pkg::MODE_LONG));
      kind_q        <= status_q[1:0];
      crc_ok_q      <= status_q[16];
      ack_request_q <= status_q[17];
      match_out_q   <= match_q;
      mode_out_q    <= pan_eq ? mode : 2'd0;
      if (!pan_eq) begin
        daddr_q <= '0;
        saddr_q <= '0;
      end else if (mode == ffilt_pkg::MODE_LONG) begin
        daddr_q <= {dhi_q, dlo_q};
        saddr_q <= {shi_q, slo_q};
      end else begin
        daddr_q <= {32'd0, dlo_q};
        saddr_q <= {32'd0, slo_q};
      end
    end
  end

  assign out_valid_o          = out_valid_q;
  assign frame_valid_o        = frame_valid_q;
  assign kind_of_frame_o      = kind_q;
  assign crc_ok_o             = crc_ok_q;
  assign ack_request_o        = ack_request_q;
  assign match_result_o       = match_out_q;
  assign dest_mode_out_o      = mode_out_q;
  assign dest_address_out_o   = daddr_q;
  assign source_address_out_o = saddr_q;

endmodule
